FILE: src/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding-window median filter.
// ---------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int RING_DEPTH_DEF   = 32;
  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int              WIN_W     = 6;
  localparam logic [WIN_W-1:0] WIN_RESET = 6'd32;

  // per-cycle command to the sorted cell row
  typedef struct packed {
    logic ins;   // insert new sample, drop the oldest
    logic rot;   // rotate row one place toward cell 0
  } cell_ctl_t;

  // command to the rank selector
  typedef struct packed {
    logic clr;   // start of a new scan
    logic step;  // tap holds a valid sorted element
  } rank_ctl_t;

endpackage

`default_nettype wire

FILE: src/swm_cell.sv
// ---------------------------------------------------------------------------
// swm_cell
// One place of the sorted row: holds a sample and its age, takes part in
// insert/evict and in the rotation that streams the row out.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int RING_DEPTH   = RING_DEPTH_DEF,
  parameter int INDEX        = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire cell_ctl_t                             ctl,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        sample,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        left_value,
  input  wire logic        [$clog2(RING_DEPTH)-1:0]  left_age,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        right_value,
  input  wire logic        [$clog2(RING_DEPTH)-1:0]  right_age,
  input  wire logic                                  right_gt,
  input  wire logic                                  left_lt,
  input  wire logic                                  evb_self,
  input  wire logic                                  evb_left,
  output logic signed      [SAMPLE_WIDTH-1:0]        value,
  output logic             [$clog2(RING_DEPTH)-1:0]  age,
  output logic                                       gt,
  output logic                                       lt,
  output logic                                       ev
);

  localparam int AW = $clog2(RING_DEPTH);

  logic signed [SAMPLE_WIDTH-1:0] value_r, value_nxt;
  logic        [AW-1:0]           age_r, age_nxt;
  logic signed [SAMPLE_WIDTH-1:0] keep_v, shift_v;
  logic        [AW-1:0]           keep_a, shift_a;

  assign value = value_r;
  assign age   = age_r;

  always_comb begin
    gt = value_r > sample;
    ev = age_r == AW'(RING_DEPTH - 1);
    // list with the evicted entry removed, seen from this place
    lt      = !(evb_self ? right_gt : gt);
    keep_v  = evb_self ? right_value : value_r;
    keep_a  = evb_self ? right_age   : age_r;
    shift_v = evb_left ? value_r : left_value;
    shift_a = evb_left ? age_r   : left_age;
    value_nxt = value_r;
    age_nxt   = age_r;
    if (ctl.ins) begin
      if (lt) begin
        value_nxt = keep_v;
        age_nxt   = keep_a + AW'(1);
      end else if (left_lt) begin
        value_nxt = sample;
        age_nxt   = '0;
      end else begin
        value_nxt = shift_v;
        age_nxt   = shift_a + AW'(1);
      end
    end else if (ctl.rot) begin
      value_nxt = right_value;
      age_nxt   = right_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      age_r   <= AW'(INDEX);
    end else begin
      value_r <= value_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/swm_rank.sv
// ---------------------------------------------------------------------------
// swm_rank
// Counts in-window elements as the sorted row streams past and captures the
// two middle ranks.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_rank
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire rank_ctl_t                              ctl,
  input  wire logic        [$clog2(RING_DEPTH+1)-1:0] win_n,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         tap_value,
  input  wire logic        [$clog2(RING_DEPTH)-1:0]   tap_age,
  output logic signed      [SAMPLE_WIDTH-1:0]         lo,
  output logic signed      [SAMPLE_WIDTH-1:0]         hi
);

  localparam int NW = $clog2(RING_DEPTH + 1);

  logic        [NW-1:0]           rank_r;
  logic signed [SAMPLE_WIDTH-1:0] lo_r, hi_r;
  logic        [NW-1:0]           k_lo, k_hi;
  logic                           in_win;

  assign k_lo   = (win_n - NW'(1)) >> 1;
  assign k_hi   = win_n >> 1;
  assign in_win = NW'(tap_age) < win_n;
  assign lo     = lo_r;
  assign hi     = hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
    end else if (ctl.clr) begin
      rank_r <= '0;
    end else if (ctl.step && in_win) begin
      rank_r <= rank_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && in_win) begin
      if (rank_r == k_lo) begin
        lo_r <= tap_value;
      end
      if (rank_r == k_hi) begin
        hi_r <= tap_value;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/sliding_window_median.sv
// ---------------------------------------------------------------------------
// sliding_window_median
// Running median over the newest window_length samples, kept as a sorted row
// of cells with ages; result is twice the median.
// ---------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_*     in   tdata[23:0] sample (signed)
//  out_*    out  tdata[24:0] median_twice (signed), upper bits zero
//  cfg_*    in   wr_data[5:0] window_length, written when wr_en is high
//
//  Accept cycle inserts the sample and evicts the oldest entry in one step.
//  The row then rotates a full turn through cell 0 for rank selection
//  (ST_SCAN); ST_HOLD registers the result beat once the output is free,
//  and the next sample is taken only back in ST_IDLE. A waiting result
//  beat does not block the next accept; the scan end waits. Reset (rst_n
//  low, synchronous) zeroes cell values, sets ages to cell index, window to 32.
// ---------------------------------------------------------------------------
`default_nettype none

module sliding_window_median
  import swm_pkg::*;
#(
  parameter int RING_DEPTH   = RING_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_wr_en,
  input  wire logic [WIN_W-1:0]                        cfg_wr_data,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,   // sample
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic      [((SAMPLE_WIDTH+8)/8)*8-1:0]       out_tdata   // median_twice
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int NW    = $clog2(RING_DEPTH + 1);
  localparam int OUT_W = ((SAMPLE_WIDTH + 8) / 8) * 8;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_t;

  state_t                          state_r;
  logic [AW-1:0]                   scan_cnt_r;
  logic                            out_valid_r;
  logic [SAMPLE_WIDTH:0]           out_data_r;
  logic [WIN_W-1:0]                win_len_r;

  logic                            in_acc;
  logic                            out_free;
  logic signed [SAMPLE_WIDTH-1:0]  sample;
  logic [NW-1:0]                   win_n;
  cell_ctl_t                       cell_ctl;
  rank_ctl_t                       rank_ctl;
  logic signed [SAMPLE_WIDTH-1:0]  lo, hi;

  logic signed [SAMPLE_WIDTH-1:0]  cell_value [RING_DEPTH];
  logic        [AW-1:0]            cell_age   [RING_DEPTH];
  logic        [RING_DEPTH-1:0]    cell_gt, cell_lt, cell_ev, evb;

  assign in_tready  = state_r == ST_IDLE;
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign sample     = in_tdata[SAMPLE_WIDTH-1:0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WIN_RESET;
    end else if (cfg_wr_en) begin
      win_len_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (win_len_r == '0) begin
      win_n = NW'(1);
    end else if (32'(win_len_r) > 32'(RING_DEPTH)) begin
      win_n = NW'(RING_DEPTH);
    end else begin
      win_n = NW'(win_len_r);
    end
  end

  // evb[i]: the oldest entry sits at or left of cell i
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      acc    = acc | cell_ev[i];
      evb[i] = acc;
    end
  end

  assign cell_ctl.ins  = in_acc;
  assign cell_ctl.rot  = state_r == ST_SCAN;
  assign rank_ctl.clr  = in_acc;
  assign rank_ctl.step = state_r == ST_SCAN;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .RING_DEPTH   (RING_DEPTH),
      .INDEX        (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl),
      .sample      (sample),
      .left_value  (cell_value[(i == 0) ? 0 : i - 1]),
      .left_age    (cell_age[(i == 0) ? 0 : i - 1]),
      .right_value (cell_value[(i + 1) % RING_DEPTH]),
      .right_age   (cell_age[(i + 1) % RING_DEPTH]),
      .right_gt    ((i == RING_DEPTH - 1) ? 1'b1 : cell_gt[(i + 1) % RING_DEPTH]),
      .left_lt     ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1]),
      .evb_self    (evb[i]),
      .evb_left    ((i == 0) ? 1'b0 : evb[(i == 0) ? 0 : i - 1]),
      .value       (cell_value[i]),
      .age         (cell_age[i]),
      .gt          (cell_gt[i]),
      .lt          (cell_lt[i]),
      .ev          (cell_ev[i])
    );
  end

  swm_rank #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .RING_DEPTH   (RING_DEPTH)
  ) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rank_ctl),
    .win_n     (win_n),
    .tap_value (cell_value[0]),
    .tap_age   (cell_age[0]),
    .lo        (lo),
    .hi        (hi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r    <= ST_SCAN;
            scan_cnt_r <= '0;
          end
        end
        ST_SCAN: begin
          scan_cnt_r <= scan_cnt_r + AW'(1);
          if (scan_cnt_r == AW'(RING_DEPTH - 1)) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {lo[SAMPLE_WIDTH-1], lo} + {hi[SAMPLE_WIDTH-1], hi};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/swm_checker.sv
// ---------------------------------------------------------------------------
// swm_checker
// Port-level checks of the median filter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_checker
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [((SAMPLE_WIDTH+8)/8)*8-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out beat changed while stalled");

  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a beat");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result beat one cycle after accept");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind sliding_window_median swm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
